[hw/rtl/huffman_tree_load_and_decode_defines.svh]
// Assertion macros used by the checker of the Huffman tree decoder.
`ifndef HUFFMAN_TREE_LOAD_AND_DECODE_DEFINES_SVH
`define HUFFMAN_TREE_LOAD_AND_DECODE_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define HUFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hufd check failed");

// Check that a condition holds in the cycle after its trigger.
`define HUFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hufd check failed");

`endif

[hw/rtl/hufd_pkg.sv]
// Shared constants and types of the Huffman tree decoder.
package hufd_pkg;

  typedef logic [1:0] status_t;

  // Default table sizes
  localparam int unsigned NODE_DEPTH_DEF  = 512;
  localparam int unsigned STACK_DEPTH_DEF = 256;

  // Stream markers
  localparam logic [7:0] MARK_INNER = 8'h30;
  localparam logic [7:0] MARK_LEAF  = 8'h31;
  localparam logic [7:0] MARK_SEP   = 8'h23;

  // Result status codes
  localparam status_t ST_SYMBOL   = 2'd0;
  localparam status_t ST_BAD_MARK = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;

endpackage

[hw/rtl/hufd_if.sv]
// Input and result channel interfaces of the Huffman tree decoder.
interface hufd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] stream_byte;

  modport source (output valid, output action, output stream_byte, input ready);
  modport sink   (input valid, input action, input stream_byte, output ready);
endinterface

interface hufd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output symbol, output status, output last, input ready);
  modport sink   (input valid, input symbol, input status, input last, output ready);
endinterface

[hw/rtl/huffman_tree_load_and_decode.sv]
// Huffman decoder with a pre-order code tree loaded from the stream.
//
// The block takes one stream word at a time. Tree words ('0' internal node, '1' plus a
// symbol word for a leaf) build a node table in a single-port-write memory, with a second
// memory as the stack of internal nodes still waiting for a right child. After the tree
// closes, one optional '#' word is skipped and every later word is walked MSB first, one
// bit per cycle unless the result side stalls, emitting a symbol for each leaf reached. A
// tree word is accepted, then executed, with a stack pop after it when a leaf closes a
// subtree; a data word goes through accept, first node-table read, eight bit steps and a
// final flush. The bit steps are set by the node-table read port: each bit needs one
// registered read of the child entry. Results of a word are held back by one so the last
// one can be flagged; a malformed tree word or an overflow gives one error result and
// halts the block until a clear word.
module huffman_tree_load_and_decode #(
  parameter int unsigned NODE_DEPTH  = hufd_pkg::NODE_DEPTH_DEF,
  parameter int unsigned STACK_DEPTH = hufd_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hufd_in_if.sink   in_i,
  hufd_out_if.source out_o
);
  import hufd_pkg::*;

  localparam int unsigned IW  = $clog2(NODE_DEPTH);
  localparam int unsigned CW  = $clog2(NODE_DEPTH + 1);
  localparam int unsigned RW  = (CW > 8) ? CW : 8;
  localparam int unsigned EW  = 1 + CW + RW;
  localparam int unsigned SIW = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  // Stream phases
  localparam logic [2:0] PH_MARK = 3'd0;
  localparam logic [2:0] PH_SYM  = 3'd1;
  localparam logic [2:0] PH_SEP  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_HALT = 3'd4;

  // Pick the child of an entry for one code bit; an index past the table goes to the root
  function automatic logic [IW-1:0] child_sel(logic [EW-1:0] e, logic b);
    logic [RW-1:0] c;
    c = b ? e[RW-1:0] : RW'(e[RW+CW-1:RW]);
    child_sel = (c >= RW'(NODE_DEPTH)) ? '0 : c[IW-1:0];
  endfunction

  // Memories
  logic [EW-1:0] node_mem_q [NODE_DEPTH];
  logic [IW-1:0] stk_mem_q  [STACK_DEPTH];

  // Control registers
  logic [2:0]     st_q, st_d;
  logic [2:0]     phase_q, phase_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [CW-1:0]  nfree_q, nfree_d;
  logic [IW-1:0]  cur_q, cur_d;
  logic           pend_v_q, pend_v_d;
  logic           out_valid_q;

  // Payload registers
  logic           act_q, act_d;
  logic [7:0]     byte_q, byte_d;
  logic [2:0]     cnt_q, cnt_d;
  logic [IW-1:0]  nx_q, nx_d;
  logic [EW-1:0]  cur_ent_q, cur_ent_d;
  logic [EW-1:0]  root_q, root_d;
  logic [EW-1:0]  rdata_q;
  logic [IW-1:0]  stk_q;
  logic [7:0]     pend_sym_q, pend_sym_d;
  logic [7:0]     out_sym_q;
  status_t        out_stat_q;
  logic           out_last_q;

  // Memory ports
  logic           mem_we, mem_re;
  logic [IW-1:0]  mem_waddr, mem_raddr;
  logic [EW-1:0]  mem_wdata;
  logic           stk_we, stk_re;
  logic [SIW-1:0] stk_waddr, stk_raddr;
  logic [IW-1:0]  stk_wdata;

  // Result push
  logic           push, push_last;
  logic [7:0]     push_sym;
  status_t        push_stat;

  // Helpers
  logic           out_free, node_full, stack_full, fail, hit, root_leaf, stall;
  status_t        fail_st;
  logic [CW-1:0]  nfree_inc, t_inc;
  logic [SPW-1:0] sp_dec;
  logic [EW-1:0]  cur_ent, ne;
  logic [IW-1:0]  nx_sel;
  logic [7:0]     hsym;

  assign out_free   = !out_valid_q || out_o.ready;
  assign node_full  = (nfree_q >= CW'(NODE_DEPTH));
  assign stack_full = (sp_q >= SPW'(STACK_DEPTH));
  assign nfree_inc  = nfree_q + 1'b1;
  assign t_inc      = CW'(stk_q) + CW'(1);
  assign sp_dec     = sp_q - 1'b1;
  assign cur_ent    = (cur_q == '0) ? root_q : cur_ent_q;
  assign root_leaf  = root_q[EW-1];
  assign hit        = root_leaf || rdata_q[EW-1];
  assign hsym       = root_leaf ? root_q[7:0] : rdata_q[7:0];
  assign stall      = hit && pend_v_q && !out_free;

  assign in_i.ready = (st_q == S_IDLE);

  // Sequencer
  always_comb begin
    st_d       = st_q;
    phase_d    = phase_q;
    sp_d       = sp_q;
    nfree_d    = nfree_q;
    cur_d      = cur_q;
    pend_v_d   = pend_v_q;
    act_d      = act_q;
    byte_d     = byte_q;
    cnt_d      = cnt_q;
    nx_d       = nx_q;
    cur_ent_d  = cur_ent_q;
    pend_sym_d = pend_sym_q;
    mem_we     = 1'b0;
    mem_waddr  = nfree_q[IW-1:0];
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    stk_we     = 1'b0;
    stk_waddr  = sp_q[SIW-1:0];
    stk_wdata  = nfree_q[IW-1:0];
    stk_re     = 1'b0;
    stk_raddr  = sp_dec[SIW-1:0];
    push       = 1'b0;
    push_sym   = '0;
    push_stat  = ST_SYMBOL;
    push_last  = 1'b0;
    fail       = 1'b0;
    fail_st    = ST_OVERFLOW;
    ne         = root_q;
    nx_sel     = '0;

    unique case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d  = in_i.action;
          byte_d = in_i.stream_byte;
          st_d   = S_EXEC;
        end
      end

      S_EXEC: begin
        if (act_q) begin
          // Clear: drop the tree and restart
          sp_d    = '0;
          nfree_d = '0;
          cur_d   = '0;
          phase_d = PH_MARK;
          st_d    = S_IDLE;
        end else begin
          case (phase_q) inside
            PH_MARK: begin
              if (byte_q == MARK_INNER) begin
                if (node_full || stack_full) begin
                  fail = 1'b1;
                end else begin
                  // Create internal node, left child is the next node
                  mem_we    = 1'b1;
                  mem_wdata = {1'b0, nfree_inc, {RW{1'b0}}};
                  stk_we    = 1'b1;
                  sp_d      = sp_q + 1'b1;
                  nfree_d   = nfree_inc;
                  st_d      = S_IDLE;
                end
              end else if (byte_q == MARK_LEAF) begin
                if (node_full) begin
                  fail = 1'b1;
                end else begin
                  phase_d = PH_SYM;
                  st_d    = S_IDLE;
                end
              end else begin
                fail    = 1'b1;
                fail_st = ST_BAD_MARK;
              end
            end
            PH_SYM: begin
              if (node_full) begin
                fail = 1'b1;
              end else begin
                // Create leaf, then close the newest open internal node, if any
                mem_we    = 1'b1;
                mem_wdata = {1'b1, {CW{1'b0}}, RW'(byte_q)};
                nfree_d   = nfree_inc;
                if (sp_q == '0) begin
                  phase_d = PH_SEP;
                  cur_d   = '0;
                  st_d    = S_IDLE;
                end else begin
                  stk_re  = 1'b1;
                  sp_d    = sp_dec;
                  phase_d = PH_MARK;
                  st_d    = S_POP;
                end
              end
            end
            PH_SEP, PH_DATA: begin
              phase_d = PH_DATA;
              if (phase_q == PH_SEP && byte_q == MARK_SEP) begin
                st_d = S_IDLE;
              end else begin
                // Start the walk: fetch the child for the top bit
                nx_sel    = child_sel(cur_ent, byte_q[7]);
                mem_re    = 1'b1;
                mem_raddr = nx_sel;
                nx_d      = nx_sel;
                cnt_d     = '0;
                st_d      = S_EVAL;
              end
            end
            default: begin
              st_d = S_IDLE;
            end
          endcase

          // Report an error once the result slot is free, then halt
          if (fail) begin
            if (out_free) begin
              push      = 1'b1;
              push_stat = fail_st;
              push_last = 1'b1;
              phase_d   = PH_HALT;
              st_d      = S_IDLE;
            end else begin
              st_d = S_EXEC;
            end
          end
        end
      end

      S_POP: begin
        // Set the right child of the popped node to the next free node
        mem_we    = 1'b1;
        mem_waddr = stk_q;
        mem_wdata = {1'b0, t_inc, RW'(nfree_q)};
        st_d      = S_IDLE;
      end

      S_EVAL: begin
        if (!stall) begin
          if (hit) begin
            // Leaf: release the held symbol, hold the new one, back to root
            if (pend_v_q) begin
              push     = 1'b1;
              push_sym = pend_sym_q;
            end
            pend_v_d   = 1'b1;
            pend_sym_d = hsym;
            cur_d      = '0;
            ne         = root_q;
          end else begin
            cur_d     = nx_q;
            cur_ent_d = rdata_q;
            ne        = rdata_q;
          end
          byte_d = {byte_q[6:0], 1'b0};
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q == 3'd7) begin
            st_d = S_FLUSH;
          end else begin
            nx_sel    = child_sel(ne, byte_q[6]);
            mem_re    = 1'b1;
            mem_raddr = nx_sel;
            nx_d      = nx_sel;
          end
        end
      end

      S_FLUSH: begin
        // Release the last held symbol of the word, flagged last
        if (!pend_v_q) begin
          st_d = S_IDLE;
        end else if (out_free) begin
          push      = 1'b1;
          push_sym  = pend_sym_q;
          push_last = 1'b1;
          pend_v_d  = 1'b0;
          st_d      = S_IDLE;
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Track the root entry so the walk needs no extra read
  always_comb begin
    root_d = root_q;
    if (mem_we && mem_waddr == '0) begin
      root_d = mem_wdata;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      phase_q     <= PH_MARK;
      sp_q        <= '0;
      nfree_q     <= '0;
      cur_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      phase_q  <= phase_d;
      sp_q     <= sp_d;
      nfree_q  <= nfree_d;
      cur_q    <= cur_d;
      pend_v_q <= pend_v_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    byte_q     <= byte_d;
    cnt_q      <= cnt_d;
    nx_q       <= nx_d;
    cur_ent_q  <= cur_ent_d;
    root_q     <= root_d;
    pend_sym_q <= pend_sym_d;
    if (push) begin
      out_sym_q  <= push_sym;
      out_stat_q <= push_stat;
      out_last_q <= push_last;
    end
  end

  // Node table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= node_mem_q[mem_raddr];
    end
  end

  // Stack of open internal nodes
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem_q[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stk_mem_q[stk_raddr];
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.symbol = out_sym_q;
  assign out_o.status = out_stat_q;
  assign out_o.last   = out_last_q;

endmodule

[hw/rtl/hufd_checker.sv]
// Port checker of the Huffman tree decoder and its bind to the top level.
`include "huffman_tree_load_and_decode_defines.svh"

module hufd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_symbol_i,
  input logic [1:0] out_status_i,
  input logic       out_last_i
);
  import hufd_pkg::*;

  // A stalled result word holds
  `HUFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_symbol_i) && $stable(out_status_i) && $stable(out_last_i))

  // An error result carries no symbol and ends its word
  `HUFD_ASSERT_IMPL(a_err_form, clk_i, rst_ni, out_valid_i && out_status_i != ST_SYMBOL, out_symbol_i == 8'h00 && out_last_i)

  // Only defined status codes leave the block
  `HUFD_ASSERT_IMPL(a_status_code, clk_i, rst_ni, out_valid_i, out_status_i == ST_SYMBOL || out_status_i == ST_BAD_MARK || out_status_i == ST_OVERFLOW)

  // An accepted word is worked on before the next is taken
  `HUFD_ASSERT_NEXT(a_one_word, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

endmodule

bind huffman_tree_load_and_decode hufd_checker u_hufd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_symbol_i (out_o.symbol),
  .out_status_i (out_o.status),
  .out_last_i   (out_o.last)
);

[tb/sv/huffman_tree_load_and_decode_test.sv]
// Self-checking testbench of the Huffman tree decoder: random streams, stalls, malformed trees.
module huffman_tree_load_and_decode_test;
  import hufd_pkg::*;

  localparam int NODE_SLOTS      = NODE_DEPTH_DEF;
  localparam int STACK_SLOTS     = STACK_DEPTH_DEF;
  localparam int LEAF_BIT        = 18;
  localparam int TOTAL_WORDS     = 260;
  localparam int CALM_WORDS      = 40;
  localparam int WATCHDOG_CYCLES = 1000;
  localparam int DRAIN_CYCLES    = 40;

  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    PARSE_MARK, PARSE_SYMBOL, PARSE_SEP, PARSE_DATA, PARSE_HALT
  } parse_phase_e;

  typedef struct packed {
    logic       action;
    logic [7:0] stream_byte;
  } stream_word_t;

  typedef struct packed {
    logic [7:0] symbol;
    status_t    status;
    logic       last;
  } decoded_t;

  logic clk_i;
  logic rst_ni;

  hufd_in_if  in_bus ();
  hufd_out_if out_bus ();

  huffman_tree_load_and_decode #(
    .NODE_DEPTH (NODE_SLOTS),
    .STACK_DEPTH(STACK_SLOTS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  stream_word_t stream_words[$];
  decoded_t     pending_decodes[$];

  // Decoder copy: node table, open-node stack and walk position
  logic [18:0]  code_tree [NODE_SLOTS];
  logic [8:0]   open_nodes [STACK_SLOTS];
  int           open_count = 0;
  int           node_count = 0;
  logic [8:0]   walk_node = '0;
  parse_phase_e parse_phase = PARSE_MARK;

  int stimulus_words = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  int in_idle_pct = 20;
  int out_idle_pct = 20;
  bit calm_tail = 1'b0;
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- prediction

  task automatic halt_with(input status_t code);
    pending_decodes.push_back('{symbol: 8'h00, status: code, last: 1'b1});
    parse_phase = PARSE_HALT;
  endtask

  // Walk one data word MSB first, emitting a symbol at each leaf
  task automatic walk_data_byte(input logic [7:0] bits);
    logic [18:0] entry;
    logic [8:0]  child;
    logic [7:0]  found [8];
    int          n;
    n = 0;
    for (int i = 7; i >= 0; i--) begin
      if (code_tree[0][LEAF_BIT]) begin
        // root is a leaf: every bit yields its symbol
        found[n] = code_tree[0][7:0];
        n++;
        walk_node = '0;
      end else begin
        entry = code_tree[walk_node];
        child = bits[i] ? entry[8:0] : entry[17:9];
        entry = code_tree[child];
        if (entry[LEAF_BIT]) begin
          found[n] = entry[7:0];
          n++;
          walk_node = '0;
        end else begin
          walk_node = child;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      pending_decodes.push_back('{symbol: found[k], status: ST_SYMBOL, last: (k == n - 1)});
    end
  endtask

  task automatic track_word(input stream_word_t w);
    logic [8:0] parent;
    if (w.action == ACT_CLEAR) begin
      open_count  = 0;
      node_count  = 0;
      walk_node   = '0;
      parse_phase = PARSE_MARK;
    end else begin
      case (parse_phase)
        PARSE_MARK: begin
          if (w.stream_byte == MARK_INNER) begin
            if (node_count >= NODE_SLOTS || open_count >= STACK_SLOTS) begin
              halt_with(ST_OVERFLOW);
            end else begin
              // left child is always the next node; right child patched on pop
              code_tree[node_count] = {1'b0, 9'(node_count + 1), 9'd0};
              open_nodes[open_count] = 9'(node_count);
              open_count++;
              node_count++;
            end
          end else if (w.stream_byte == MARK_LEAF) begin
            if (node_count >= NODE_SLOTS) halt_with(ST_OVERFLOW);
            else parse_phase = PARSE_SYMBOL;
          end else begin
            halt_with(ST_BAD_MARK);
          end
        end
        PARSE_SYMBOL: begin
          if (node_count >= NODE_SLOTS) begin
            halt_with(ST_OVERFLOW);
          end else begin
            code_tree[node_count] = {1'b1, 10'd0, w.stream_byte};
            node_count++;
            if (open_count == 0) begin
              parse_phase = PARSE_SEP;
              walk_node   = '0;
            end else begin
              open_count--;
              parent = open_nodes[open_count];
              code_tree[parent][8:0] = 9'(node_count);
              parse_phase = PARSE_MARK;
            end
          end
        end
        PARSE_SEP: begin
          parse_phase = PARSE_DATA;
          if (w.stream_byte != MARK_SEP) walk_data_byte(w.stream_byte);
        end
        PARSE_DATA: walk_data_byte(w.stream_byte);
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_word(input logic act, input logic [7:0] b);
    stream_words.push_back('{action: act, stream_byte: b});
    stimulus_words++;
  endtask

  task automatic push_leaf(input logic [7:0] sym);
    push_word(ACT_BYTE, MARK_LEAF);
    push_word(ACT_BYTE, sym);
  endtask

  // Random pre-order subtree with the given number of leaves
  task automatic add_subtree(input int leaves);
    int split;
    if (leaves <= 1) begin
      push_leaf(8'($urandom_range(0, 255)));
    end else begin
      split = $urandom_range(1, leaves - 1);
      push_word(ACT_BYTE, MARK_INNER);
      add_subtree(split);
      add_subtree(leaves - split);
    end
  endtask

  // Right-leaning chain: each internal node gets a leaf on its left
  task automatic add_chain(input int inner);
    repeat (inner) begin
      push_word(ACT_BYTE, MARK_INNER);
      push_leaf(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_stream();
    int roll;
    int leaves;
    roll = $urandom_range(0, 99);
    push_word(ACT_CLEAR, 8'($urandom_range(0, 255)));
    if (roll < 80) begin
      // well-formed tree, optional separator, coded data
      leaves = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      add_subtree(leaves);
      if ($urandom_range(0, 1)) push_word(ACT_BYTE, MARK_SEP);
      repeat ($urandom_range(0, 10)) push_word(ACT_BYTE, 8'($urandom_range(0, 255)));
    end else if (roll < 92) begin
      // partial tree, then a random marker and bytes that a halted block drops
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 1)) push_word(ACT_BYTE, MARK_INNER);
        else push_leaf(8'($urandom_range(0, 255)));
      end
      push_word(ACT_BYTE, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) begin
        push_word(ACT_BYTE, 8'($urandom_range(0, 255)));
      end
    end else begin
      // tree abandoned midway by the next clear
      push_word(ACT_BYTE, MARK_INNER);
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 1)) push_word(ACT_BYTE, MARK_INNER);
        else push_word(ACT_BYTE, MARK_LEAF);
      end
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin
    // vary idle density so that quiet stretches and busy stretches both occur
    if ($urandom_range(0, 127) == 0) begin
      case ($urandom_range(0, 3))
        0: in_idle_pct = 0;
        1: in_idle_pct = 10;
        2: in_idle_pct = 25;
        default: in_idle_pct = 50;
      endcase
    end
    if ($urandom_range(0, 127) == 0) begin
      case ($urandom_range(0, 3))
        0: out_idle_pct = 0;
        1: out_idle_pct = 10;
        2: out_idle_pct = 25;
        default: out_idle_pct = 50;
      endcase
    end
    calm_tail = (stream_words.size() <= CALM_WORDS);

    if (!rst_ni) begin
      in_bus.valid  <= 1'b0;
      out_bus.ready <= 1'b0;
    end else begin
      // hold a presented word until it is taken
      if (!in_bus.valid || in_fire) begin
        if (in_gap > 0) begin
          in_bus.valid <= 1'b0;
          in_gap--;
        end else if (!calm_tail && $urandom_range(1, 100) <= in_idle_pct) begin
          in_bus.valid <= 1'b0;
          in_gap = $urandom_range(0, 10);
        end else if (stream_words.size() > 0) begin
          in_bus.valid       <= 1'b1;
          in_bus.action      <= stream_words[0].action;
          in_bus.stream_byte <= stream_words[0].stream_byte;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end

      // stall the result side in bursts
      if (out_gap > 0) begin
        out_bus.ready <= 1'b0;
        out_gap--;
      end else if (!calm_tail && $urandom_range(1, 100) <= out_idle_pct) begin
        out_bus.ready <= 1'b0;
        out_gap = $urandom_range(0, 10);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic flag_field(input string field, input logic [7:0] want_v,
                            input logic [7:0] got_v);
    mismatches++;
    $error("%s: expected %0h, got %0h", field, want_v, got_v);
  endtask

  always @(posedge clk_i) begin
    decoded_t     want;
    stream_word_t taken;
    in_fire  = rst_ni && in_bus.valid && in_bus.ready;
    out_fire = rst_ni && out_bus.valid && out_bus.ready;

    // check the result word against the oldest prediction
    if (out_fire) begin
      if (pending_decodes.size() == 0) begin
        mismatches++;
        $error("result with nothing pending: symbol %0h status %0d last %0b",
               out_bus.symbol, out_bus.status, out_bus.last);
      end else begin
        want = pending_decodes.pop_front();
        if (out_bus.symbol !== want.symbol) flag_field("symbol", want.symbol, out_bus.symbol);
        if (out_bus.status !== want.status) begin
          flag_field("status", {6'd0, want.status}, {6'd0, out_bus.status});
        end
        if (out_bus.last !== want.last) flag_field("last", {7'd0, want.last}, {7'd0, out_bus.last});
      end
    end

    // advance the decoder copy on every taken stream word
    if (in_fire) begin
      taken = stream_words.pop_front();
      track_word(taken);
    end

    if (rst_ni) begin
      if (in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    in_bus.valid       = 1'b0;
    in_bus.action      = ACT_BYTE;
    in_bus.stream_byte = 8'h00;
    out_bus.ready      = 1'b0;
    rst_ni             = 1'b0;

    // single-leaf tree: every data bit yields the root symbol
    push_leaf(8'hFF);
    push_word(ACT_BYTE, MARK_SEP);
    push_word(ACT_BYTE, 8'h00);
    push_word(ACT_BYTE, 8'hFF);
    // two leaves, no separator: the first data word is decoded, a later '#' is data
    push_word(ACT_CLEAR, 8'hFF);
    push_word(ACT_BYTE, MARK_INNER);
    push_leaf(8'h00);
    push_leaf(8'hFF);
    push_word(ACT_BYTE, 8'hA5);
    push_word(ACT_BYTE, MARK_SEP);
    // bad marker at the root, then words a halted block drops
    push_word(ACT_CLEAR, 8'h00);
    push_word(ACT_BYTE, 8'hFF);
    push_word(ACT_BYTE, MARK_INNER);
    push_word(ACT_BYTE, 8'h00);
    // bad marker below an internal node
    push_word(ACT_CLEAR, 8'h5A);
    push_word(ACT_BYTE, MARK_INNER);
    push_word(ACT_BYTE, 8'h00);
    // clear while a leaf symbol is awaited
    push_word(ACT_CLEAR, MARK_INNER);
    push_word(ACT_BYTE, MARK_LEAF);
    // right-leaning chain, then a deep walk down the right spine
    push_word(ACT_CLEAR, 8'($urandom_range(0, 255)));
    add_chain(20);
    push_leaf(8'($urandom_range(0, 255)));
    push_word(ACT_BYTE, MARK_SEP);
    repeat (4) push_word(ACT_BYTE, 8'hFF);
    repeat (4) push_word(ACT_BYTE, 8'($urandom_range(0, 255)));

    while (stimulus_words < TOTAL_WORDS) add_stream();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (stream_words.size() != 0 || pending_decodes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
